// ----- rtl/smtrob_pkg.sv -----
// Shared types, constants and helpers for the SMT reorder-buffer manager.
// No dependencies; imported by every module of the block.
package smtrob_pkg;

  localparam int THREADS        = 4;
  localparam int MAX_PER_THREAD = 64;
  localparam int SLOTS          = THREADS * MAX_PER_THREAD;
  localparam int SLOT_W         = $clog2(SLOTS);
  localparam int TID_W          = 2;
  localparam int TAG_W          = 16;
  localparam int CNT_W          = 9;
  localparam int EPT_W          = 7;
  localparam int OP_W           = 3;
  localparam int ST_W           = 2;
  localparam int IDX_W          = 8;

  localparam logic [OP_W-1:0] OP_ENQ      = 3'd0;
  localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_RD_HEAD  = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_TAIL  = 3'd4;
  localparam logic [OP_W-1:0] OP_RD_NTH   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_EPT  = 1'b1;

  localparam logic [EPT_W-1:0] EPT_RESET = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_CAP, S_WALK, S_TRIM, S_OWN, S_FIN
  } state_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic cap;
    logic walk;
    logic trim;
    logic own;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic mode;
    logic walk_req;
    logic walk_done;
    logic trim_done;
    logic out_free;
  } ctl_sts_t;

  function automatic logic [EPT_W-1:0] eff_size(input logic [EPT_W-1:0] v);
    logic [EPT_W-1:0] r;
    r = v;
    if (v == '0) r = EPT_W'(1);
    if (v > EPT_W'(MAX_PER_THREAD)) r = EPT_W'(MAX_PER_THREAD);
    return r;
  endfunction

endpackage

// ----- rtl/smtrob_ctrl.sv -----
// Sequencer for the reorder-buffer manager: steps one item through its phases.
// Depends on smtrob_pkg; drives smtrob_dp through ctl_cmd_t.
module smtrob_ctrl import smtrob_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  ctl_sts_t sts,
  output logic     in_ready,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (!sts.mode) state_next = S_CAP;
        else if (sts.walk_req) state_next = S_WALK;
        else state_next = S_TRIM;
      end
      S_CAP:  state_next = S_FIN;
      S_WALK: if (sts.walk_done) state_next = S_TRIM;
      S_TRIM: if (sts.trim_done) state_next = S_OWN;
      S_OWN:  state_next = S_FIN;
      S_FIN:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_CAP:  cmd.cap  = 1'b1;
      S_WALK: cmd.walk = 1'b1;
      S_TRIM: cmd.trim = 1'b1;
      S_OWN:  cmd.own  = 1'b1;
      S_FIN:  cmd.fin  = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/smtrob_dp.sv -----
// Datapath: slot memory, valid bits, pointers, counts, walk and trim logic,
// result register. Depends on smtrob_pkg; commanded by smtrob_ctrl.
module smtrob_dp import smtrob_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [EPT_W-1:0]  cfg_wdata,
  input  logic [OP_W-1:0]   opcode,
  input  logic [TID_W-1:0]  thread_id,
  input  logic [TAG_W-1:0]  uop_tag,
  input  logic [IDX_W-1:0]  entry_index,
  input  ctl_cmd_t          cmd,
  output ctl_sts_t          sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   status,
  output logic [TAG_W-1:0]  entry_tag,
  output logic [CNT_W-1:0]  thread_entries,
  output logic              can_enqueue,
  output logic              can_dequeue
);

  localparam int MW = TAG_W + TID_W;

  logic [MW-1:0]     mem [SLOTS];
  logic [MW-1:0]     rd_data;
  logic [SLOTS-1:0]  valid;

  logic              rob_mode;
  logic [EPT_W-1:0]  ept;
  logic [OP_W-1:0]   op_r;
  logic [TID_W-1:0]  tid_r;
  logic [TAG_W-1:0]  tag_r;
  logic [IDX_W-1:0]  k_r;

  logic [SLOT_W-1:0] sh_head, sh_tail;
  logic [CNT_W-1:0]  sh_span;
  logic [SLOT_W-1:0] part_head [THREADS];
  logic [SLOT_W-1:0] part_tail [THREADS];
  logic [CNT_W-1:0]  live [THREADS];

  logic [SLOT_W-1:0] ptr, chk_idx;
  logic [CNT_W-1:0]  wcnt, seen;
  logic              chk_v, chk_valid;
  logic [ST_W-1:0]   res_status;
  logic [TAG_W-1:0]  res_tag;

  logic [EPT_W-1:0]  e, e_new, e_rst;
  logic [CNT_W-1:0]  total, cnt, nth_off;
  logic [SLOT_W-1:0] left, right, ph, pt, pt_m1, nth_slot, last, sh_tm1;
  logic [SLOT_W-1:0] sh_head_inc, sh_tail_inc, ptr_step, rd_addr, wr_addr;
  logic              is_head_op, is_tail_op, is_rem, is_rd_any, young;
  logic              priv_room, sh_room, walk_req, hit_now, walk_done;
  logic              head_hole, tail_hole, issue, rd_en, wr_en;
  logic [IDX_W-1:0]  walk_k;
  logic [TID_W-1:0]  rd_owner;
  logic [TAG_W-1:0]  rd_tag;

  always_comb begin
    e       = eff_size(ept);
    e_new   = (cfg_addr == CFG_EPT) ? eff_size(cfg_wdata) : e;
    e_rst   = eff_size(EPT_RESET);
    total   = CNT_W'(e) * CNT_W'(THREADS);
    last    = SLOT_W'(total - CNT_W'(1));
    cnt     = live[tid_r];
    left    = SLOT_W'(CNT_W'(tid_r) * CNT_W'(e));
    right   = left + SLOT_W'(e) - SLOT_W'(1);
    ph      = part_head[tid_r];
    pt      = part_tail[tid_r];
    pt_m1   = (pt == left) ? right : pt - SLOT_W'(1);
    nth_off = CNT_W'(ph - left) + CNT_W'(k_r);
    if (nth_off >= CNT_W'(e)) nth_off = nth_off - CNT_W'(e);
    nth_slot = left + SLOT_W'(nth_off);

    is_head_op = (op_r == OP_REM_HEAD) || (op_r == OP_RD_HEAD);
    is_tail_op = (op_r == OP_REM_TAIL) || (op_r == OP_RD_TAIL);
    is_rem     = (op_r == OP_REM_HEAD) || (op_r == OP_REM_TAIL);
    is_rd_any  = is_head_op || is_tail_op || (op_r == OP_RD_NTH);
    young      = is_tail_op;

    priv_room = cnt < CNT_W'(e);
    sh_room   = sh_span < total;
    walk_req  = ((is_head_op || is_tail_op) && (cnt != '0)) ||
                ((op_r == OP_RD_NTH) && (CNT_W'(k_r) < cnt));
    walk_k    = (op_r == OP_RD_NTH) ? k_r : '0;

    sh_tm1      = (sh_tail == '0) ? last : sh_tail - SLOT_W'(1);
    sh_head_inc = (CNT_W'(sh_head) + CNT_W'(1) >= total) ? '0 : sh_head + SLOT_W'(1);
    sh_tail_inc = (CNT_W'(sh_tail) + CNT_W'(1) >= total) ? '0 : sh_tail + SLOT_W'(1);
    if (young) ptr_step = (ptr == '0) ? last : ptr - SLOT_W'(1);
    else ptr_step = (CNT_W'(ptr) + CNT_W'(1) >= total) ? '0 : ptr + SLOT_W'(1);

    rd_owner  = rd_data[TAG_W +: TID_W];
    rd_tag    = rd_data[TAG_W-1:0];
    hit_now   = chk_v && chk_valid && (rd_owner == tid_r) && (seen == CNT_W'(walk_k));
    walk_done = hit_now || (!chk_v && (wcnt == sh_span));
    issue     = cmd.walk && (wcnt != sh_span) && !hit_now;

    head_hole = (sh_span != '0) && !valid[sh_head];
    tail_hole = (sh_span != '0) && !valid[sh_tm1];

    rd_en   = 1'b0;
    rd_addr = ptr;
    if (cmd.exec && !rob_mode && is_rd_any) begin
      rd_en = 1'b1;
      if (is_head_op) rd_addr = ph;
      else if (is_tail_op) rd_addr = pt_m1;
      else rd_addr = nth_slot;
    end else if (issue) begin
      rd_en = 1'b1;
    end else if (cmd.own) begin
      rd_en   = 1'b1;
      rd_addr = sh_head;
    end

    wr_addr = rob_mode ? sh_tail : pt;
    wr_en   = cmd.exec && (op_r == OP_ENQ) && (rob_mode ? sh_room : priv_room);

    sts.mode      = rob_mode;
    sts.walk_req  = walk_req;
    sts.walk_done = walk_done;
    sts.trim_done = !head_hole && !tail_hole;
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {tid_r, tag_r};
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= opcode;
      tid_r <= thread_id;
      tag_r <= uop_tag;
      k_r   <= entry_index;
    end
    if (cmd.fin) begin
      status         <= res_status;
      entry_tag      <= (res_status == ST_OK) ? res_tag : '0;
      thread_entries <= cnt;
      can_enqueue    <= rob_mode ? sh_room : priv_room;
      can_dequeue    <= rob_mode ? ((sh_span != '0) && (rd_owner == tid_r)) : (cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rob_mode  <= 1'b0;
      ept       <= EPT_RESET;
      valid     <= '0;
      sh_head   <= '0;
      sh_tail   <= '0;
      sh_span   <= '0;
      out_valid <= 1'b0;
      chk_v     <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        part_head[i] <= SLOT_W'(CNT_W'(i) * CNT_W'(e_rst));
        part_tail[i] <= SLOT_W'(CNT_W'(i) * CNT_W'(e_rst));
        live[i]      <= '0;
      end
    end else begin
      if (cmd.fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (cfg_we) begin
        if (cfg_addr == CFG_MODE) rob_mode <= cfg_wdata[0];
        else ept <= cfg_wdata;
        valid   <= '0;
        sh_head <= '0;
        sh_tail <= '0;
        sh_span <= '0;
        for (int i = 0; i < THREADS; i++) begin
          part_head[i] <= SLOT_W'(CNT_W'(i) * CNT_W'(e_new));
          part_tail[i] <= SLOT_W'(CNT_W'(i) * CNT_W'(e_new));
          live[i]      <= '0;
        end
      end

      if (cmd.exec) begin
        res_status <= ST_OK;
        res_tag    <= '0;
        ptr        <= young ? sh_tm1 : sh_head;
        wcnt       <= '0;
        seen       <= '0;
        chk_v      <= 1'b0;
        if (op_r == OP_ENQ) begin
          if (!(rob_mode ? sh_room : priv_room)) begin
            res_status <= ST_FULL;
          end else begin
            res_tag        <= tag_r;
            valid[wr_addr] <= 1'b1;
            live[tid_r]    <= cnt + CNT_W'(1);
            if (rob_mode) begin
              sh_tail <= sh_tail_inc;
              sh_span <= sh_span + CNT_W'(1);
            end else begin
              part_tail[tid_r] <= (pt == right) ? left : pt + SLOT_W'(1);
            end
          end
        end else if (is_head_op || is_tail_op) begin
          if (cnt == '0) begin
            res_status <= ST_EMPTY;
          end else if (!rob_mode && is_rem) begin
            live[tid_r] <= cnt - CNT_W'(1);
            if (is_head_op) begin
              valid[ph]        <= 1'b0;
              part_head[tid_r] <= (ph == right) ? left : ph + SLOT_W'(1);
            end else begin
              valid[pt_m1]     <= 1'b0;
              part_tail[tid_r] <= pt_m1;
            end
          end
        end else if (op_r == OP_RD_NTH) begin
          if (CNT_W'(k_r) >= cnt) res_status <= ST_RANGE;
        end
      end

      if (cmd.cap && (res_status == ST_OK) && is_rd_any) res_tag <= rd_tag;

      if (cmd.walk) begin
        if (chk_v && chk_valid && (rd_owner == tid_r) && !hit_now) seen <= seen + CNT_W'(1);
        if (hit_now) begin
          res_tag <= rd_tag;
          if (is_rem) begin
            valid[chk_idx] <= 1'b0;
            live[tid_r]    <= cnt - CNT_W'(1);
          end
        end else if (walk_done) begin
          res_status <= (op_r == OP_RD_NTH) ? ST_RANGE : ST_EMPTY;
        end
        if (issue) begin
          chk_v     <= 1'b1;
          chk_idx   <= ptr;
          chk_valid <= valid[ptr];
          ptr       <= ptr_step;
          wcnt      <= wcnt + CNT_W'(1);
        end else begin
          chk_v <= 1'b0;
        end
      end

      if (cmd.trim) begin
        if (head_hole) begin
          sh_head <= sh_head_inc;
          sh_span <= sh_span - CNT_W'(1);
        end else if (tail_hole) begin
          sh_tail <= sh_tm1;
          sh_span <= sh_span - CNT_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/smt_reorder_buffer_manager_core.sv -----
// Top level of the SMT reorder-buffer manager: sequencer plus datapath.
// Depends on smtrob_pkg, smtrob_ctrl and smtrob_dp.
//
// Usage: one item per transfer on the input channel (opcode, thread_id,
// uop_tag, entry_index); exactly one result per item on the output channel
// (status, entry_tag, thread_entries, can_enqueue, can_dequeue).
// Configuration: cfg_we with cfg_addr 0 writes rob_mode, 1 writes
// entries_per_thread; either write clears the buffer. Write only while idle.
// Sequence: private mode steps each item through accept, execute, slot
// memory read and result. Shared mode steps through accept, execute, a
// walk over the slots when searching a thread's entries, trimming of holes
// at both ends, head owner read and result, all on the one slot memory
// port.
// One item is in flight at a time; the next is accepted while the previous
// result still waits in the output register.
// Reset: synchronous, clears all valid bits, pointers and counts at once;
// no clearing pass is needed. A stalled receiver holds the result; the block
// finishes its current item and then waits before writing the next result.
module smt_reorder_buffer_manager_core import smtrob_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [EPT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   opcode,
  input  logic [TID_W-1:0]  thread_id,
  input  logic [TAG_W-1:0]  uop_tag,
  input  logic [IDX_W-1:0]  entry_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   status,
  output logic [TAG_W-1:0]  entry_tag,
  output logic [CNT_W-1:0]  thread_entries,
  output logic              can_enqueue,
  output logic              can_dequeue
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  smtrob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  smtrob_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .opcode         (opcode),
    .thread_id      (thread_id),
    .uop_tag        (uop_tag),
    .entry_index    (entry_index),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .entry_tag      (entry_tag),
    .thread_entries (thread_entries),
    .can_enqueue    (can_enqueue),
    .can_dequeue    (can_dequeue)
  );

endmodule
